// File: rtl/core/mcpwm_pkg.sv
// Shared types and constants of the multi-channel PWM block.
package mcpwm_pkg;

  localparam int REQ_W   = 2;
  localparam int IDX_W   = 6;
  localparam int WORD_W  = 32;
  localparam int PWM_W   = 4;
  localparam int SEL_W   = 2;
  localparam int SPARE_W = 4;

  // Bit positions inside the register words.
  localparam int BYPASS_LSB = 8;
  localparam int POL_LSB    = 8;
  localparam int SPARE_LSB  = 20;
  localparam int SEL_LSB    = 16;

  // Word indexes of the register map.
  localparam logic [IDX_W-1:0] WORD_MODE = 6'd0;
  localparam logic [IDX_W-1:0] WORD_DUTY = 6'd1;
  localparam logic [IDX_W-1:0] WORD_DIV  = 6'd17;
  localparam logic [IDX_W-1:0] WORD_POL  = 6'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // One decoded request as it is executed.
  typedef struct packed {
    logic              tick;
    logic              wr;
    logic              rd;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] data;
  } step_t;

endpackage

// File: rtl/core/mcpwm_if.sv
// Valid/ready channel interfaces for requests and results.
interface mcpwm_in_if import mcpwm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  reg_index;
  logic [WORD_W-1:0] write_data;

  modport source (output valid, req_type, reg_index, write_data, input ready);
  modport sink (input valid, req_type, reg_index, write_data, output ready);
endinterface

interface mcpwm_out_if import mcpwm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;
  logic [PWM_W-1:0]  pwm_level;

  modport source (output valid, read_data, pwm_level, input ready);
  modport sink (input valid, read_data, pwm_level, output ready);
endinterface

// File: rtl/core/mcpwm_regs.sv
// Register file: mode, polarity, duty and divider period words with read decode.
module mcpwm_regs import mcpwm_pkg::*; #(
  parameter int CHANNELS     = 4,
  parameter int DUTY_BITS    = 12,
  parameter int DIVIDER_BITS = 18
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  step_t                                  step,
  output logic [CHANNELS-1:0]                    enable_nxt,
  output logic [CHANNELS-1:0]                    bypass_nxt,
  output logic [CHANNELS-1:0]                    polarity_nxt,
  output logic [CHANNELS-1:0][DUTY_BITS-1:0]     duty_nxt,
  output logic [CHANNELS-1:0][SEL_W-1:0]         choice_nxt,
  output logic [CHANNELS-1:0][DIVIDER_BITS-1:0]  period,
  output logic [WORD_W-1:0]                      rd_data
);

  logic [CHANNELS-1:0]                   enable_r;
  logic [CHANNELS-1:0]                   bypass_r;
  logic [SPARE_W-1:0]                    spare_r;
  logic [SPARE_W-1:0]                    spare_nxt;
  logic [CHANNELS-1:0]                   polarity_r;
  logic [CHANNELS-1:0][DUTY_BITS-1:0]    duty_r;
  logic [CHANNELS-1:0][SEL_W-1:0]        choice_r;
  logic [CHANNELS-1:0][DIVIDER_BITS-1:0] period_r;
  logic [CHANNELS-1:0][DIVIDER_BITS-1:0] period_nxt;

  always_comb begin
    enable_nxt   = enable_r;
    bypass_nxt   = bypass_r;
    spare_nxt    = spare_r;
    polarity_nxt = polarity_r;
    duty_nxt     = duty_r;
    choice_nxt   = choice_r;
    period_nxt   = period_r;
    if (step.wr) begin
      if (step.idx == WORD_MODE) begin
        enable_nxt = step.data[CHANNELS-1:0];
        bypass_nxt = step.data[BYPASS_LSB +: CHANNELS];
        spare_nxt  = step.data[SPARE_LSB +: SPARE_W];
      end
      if (step.idx == WORD_POL) begin
        polarity_nxt = step.data[POL_LSB +: CHANNELS];
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (step.idx == WORD_DUTY + IDX_W'(c)) begin
          duty_nxt[c]   = step.data[DUTY_BITS-1:0];
          choice_nxt[c] = step.data[SEL_LSB +: SEL_W];
        end
        if (step.idx == WORD_DIV + IDX_W'(c)) begin
          period_nxt[c] = step.data[DIVIDER_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    rd_data = '0;
    if (step.rd) begin
      if (step.idx == WORD_MODE) begin
        rd_data[CHANNELS-1:0]              = enable_r;
        rd_data[BYPASS_LSB +: CHANNELS]    = bypass_r;
        rd_data[SPARE_LSB +: SPARE_W]      = spare_r;
      end
      if (step.idx == WORD_POL) begin
        rd_data[POL_LSB +: CHANNELS] = polarity_r;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (step.idx == WORD_DUTY + IDX_W'(c)) begin
          rd_data[DUTY_BITS-1:0]     = duty_r[c];
          rd_data[SEL_LSB +: SEL_W]  = choice_r[c];
        end
        if (step.idx == WORD_DIV + IDX_W'(c)) begin
          rd_data[DIVIDER_BITS-1:0] = period_r[c];
        end
      end
    end
  end

  assign period = period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= '0;
      bypass_r   <= '0;
      spare_r    <= '0;
      polarity_r <= '0;
      duty_r     <= '0;
      choice_r   <= '0;
      period_r   <= '0;
    end else begin
      enable_r   <= enable_nxt;
      bypass_r   <= bypass_nxt;
      spare_r    <= spare_nxt;
      polarity_r <= polarity_nxt;
      duty_r     <= duty_nxt;
      choice_r   <= choice_nxt;
      period_r   <= period_nxt;
    end
  end

endmodule

// File: rtl/core/mcpwm_div.sv
// Prescaled dividers: one prescaler and one phase counter per divider.
module mcpwm_div import mcpwm_pkg::*; #(
  parameter int CHANNELS     = 4,
  parameter int DUTY_BITS    = 12,
  parameter int DIVIDER_BITS = 18
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  step_t                                 step,
  input  logic [CHANNELS-1:0][DIVIDER_BITS-1:0] period,
  output logic [CHANNELS-1:0][DUTY_BITS-1:0]    phase_nxt
);

  for (genvar d = 0; d < CHANNELS; d++) begin : g_div
    logic [DIVIDER_BITS-1:0] count_r;
    logic [DIVIDER_BITS-1:0] count_nxt;
    logic [DUTY_BITS-1:0]    phase_r;
    logic [DUTY_BITS-1:0]    ph_nxt;
    logic [DIVIDER_BITS:0]   count_inc;

    assign count_inc = {1'b0, count_r} + {{DIVIDER_BITS{1'b0}}, 1'b1};

    // A count that already sits at or above a lowered period wraps here as well.
    always_comb begin
      count_nxt = count_r;
      ph_nxt    = phase_r;
      if (step.tick && (period[d] != '0)) begin
        if (count_inc >= {1'b0, period[d]}) begin
          count_nxt = '0;
          ph_nxt    = phase_r + {{(DUTY_BITS-1){1'b0}}, 1'b1};
        end else begin
          count_nxt = count_inc[DIVIDER_BITS-1:0];
        end
      end
    end

    assign phase_nxt[d] = ph_nxt;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        count_r <= '0;
        phase_r <= '0;
      end else begin
        count_r <= count_nxt;
        phase_r <= ph_nxt;
      end
    end
  end

endmodule

// File: rtl/core/mcpwm_level.sv
// Channel level logic: divider selection, duty compare, bypass, enable and polarity.
module mcpwm_level import mcpwm_pkg::*; #(
  parameter int CHANNELS  = 4,
  parameter int DUTY_BITS = 12
) (
  input  logic [CHANNELS-1:0]                 enable,
  input  logic [CHANNELS-1:0]                 bypass,
  input  logic [CHANNELS-1:0]                 polarity,
  input  logic [CHANNELS-1:0][DUTY_BITS-1:0]  duty,
  input  logic [CHANNELS-1:0][SEL_W-1:0]      choice,
  input  logic [CHANNELS-1:0][DUTY_BITS-1:0]  phase,
  output logic [PWM_W-1:0]                    level
);

  // Only as many dividers as the selector can name, and only the first
  // channels reach the output.
  localparam int SEL_N = (CHANNELS < (1 << SEL_W)) ? CHANNELS : (1 << SEL_W);
  localparam int OUT_N = (CHANNELS < PWM_W) ? CHANNELS : PWM_W;

  always_comb begin
    logic [DUTY_BITS-1:0] ph;
    logic                 bit_v;
    level = '0;
    for (int c = 0; c < OUT_N; c++) begin
      ph = '0;
      for (int d = 0; d < SEL_N; d++) begin
        if (choice[c] == SEL_W'(d)) begin
          ph = phase[d];
        end
      end
      bit_v = 1'b0;
      if (enable[c]) begin
        bit_v = bypass[c] | (ph < duty[c]);
      end
      level[c] = bit_v ^ polarity[c];
    end
  end

endmodule

// File: rtl/core/multi_channel_pwm_shared_dividers.sv
// Top level of the multi-channel PWM block with shared prescaled dividers.
// Each request passes the request register and then the result register; it moves on
// into the result register once that register is empty or its result is being taken.
// Throughput: one request per cycle, stalled only while the result register is held.
// Reset (synchronous, rst_n low): all configuration registers, prescalers and phases clear to zero,
// both channel registers empty.
module multi_channel_pwm_shared_dividers import mcpwm_pkg::*; #(
  parameter int CHANNELS     = 4,
  parameter int DUTY_BITS    = 12,
  parameter int DIVIDER_BITS = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  mcpwm_in_if.sink   in_ch,
  mcpwm_out_if.source out_ch
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  req_t              s1_req_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [WORD_W-1:0] s1_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_rd_r;
  logic [PWM_W-1:0]  out_lvl_r;
  logic              advance;
  logic              go;
  logic              in_ready;
  step_t             step;

  logic [CHANNELS-1:0]                   enable_nxt;
  logic [CHANNELS-1:0]                   bypass_nxt;
  logic [CHANNELS-1:0]                   polarity_nxt;
  logic [CHANNELS-1:0][DUTY_BITS-1:0]    duty_nxt;
  logic [CHANNELS-1:0][SEL_W-1:0]        choice_nxt;
  logic [CHANNELS-1:0][DIVIDER_BITS-1:0] period;
  logic [CHANNELS-1:0][DUTY_BITS-1:0]    phase_nxt;
  logic [WORD_W-1:0]                     rd_data;
  logic [PWM_W-1:0]                      level;

  // The request register moves on whenever the result register is empty or being taken.
  assign advance  = !out_valid_r || out_ch.ready;
  assign go       = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    step      = '0;
    step.idx  = s1_idx_r;
    step.data = s1_data_r;
    case (s1_req_r)
      REQ_TICK:  step.tick = go;
      REQ_WRITE: step.wr   = go;
      REQ_READ:  step.rd   = go;
      default:   step.tick = 1'b0;
    endcase
  end

  mcpwm_regs #(
    .CHANNELS     (CHANNELS),
    .DUTY_BITS    (DUTY_BITS),
    .DIVIDER_BITS (DIVIDER_BITS)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .enable_nxt   (enable_nxt),
    .bypass_nxt   (bypass_nxt),
    .polarity_nxt (polarity_nxt),
    .duty_nxt     (duty_nxt),
    .choice_nxt   (choice_nxt),
    .period       (period),
    .rd_data      (rd_data)
  );

  mcpwm_div #(
    .CHANNELS     (CHANNELS),
    .DUTY_BITS    (DUTY_BITS),
    .DIVIDER_BITS (DIVIDER_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .period    (period),
    .phase_nxt (phase_nxt)
  );

  mcpwm_level #(
    .CHANNELS  (CHANNELS),
    .DUTY_BITS (DUTY_BITS)
  ) u_level (
    .enable   (enable_nxt),
    .bypass   (bypass_nxt),
    .polarity (polarity_nxt),
    .duty     (duty_nxt),
    .choice   (choice_nxt),
    .phase    (phase_nxt),
    .level    (level)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_req_r  <= req_t'(in_ch.req_type);
      s1_idx_r  <= in_ch.reg_index;
      s1_data_r <= in_ch.write_data;
    end
    if (go) begin
      out_rd_r  <= rd_data;
      out_lvl_r <= level;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_rd_r;
  assign out_ch.pwm_level = out_lvl_r;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the four-channel PWM block with shared dividers.
module tb_top;
  import mcpwm_pkg::*;

  localparam int NCH         = 4;
  localparam int LEVEL_W     = 12;
  localparam int PERIOD_W    = 18;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [PWM_W-1:0]  pwm_level;
  } pwm_result_t;

  logic clk;
  logic rst_n;

  mcpwm_in_if  in_ch ();
  mcpwm_out_if out_ch ();

  multi_channel_pwm_shared_dividers i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted register file and counters, all clear after reset.
  logic [NCH-1:0]      chan_en    = '0;
  logic [NCH-1:0]      chan_byp   = '0;
  logic [SPARE_W-1:0]  mode_spare = '0;
  logic [NCH-1:0]      chan_inv   = '0;
  logic [PERIOD_W-1:0] div_period [NCH] = '{default: '0};
  logic [LEVEL_W-1:0]  duty_lvl   [NCH] = '{default: '0};
  logic [SEL_W-1:0]    duty_sel   [NCH] = '{default: '0};
  logic [PERIOD_W-1:0] presc_cnt  [NCH] = '{default: '0};
  logic [LEVEL_W-1:0]  phase_cnt  [NCH] = '{default: '0};

  pwm_result_t pending_results [$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  logic hold_active = 1'b0;
  event hold_start;

  int mismatches      = 0;
  int requests_sent   = 0;
  int reads_sent      = 0;
  int results_checked = 0;
  int cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the predicted state and returns the result it yields.
  function automatic pwm_result_t apply_request(input req_t rt, input logic [IDX_W-1:0] idx,
                                                input logic [WORD_W-1:0] data);
    pwm_result_t res;
    int duty_slot;
    int div_slot;
    logic [LEVEL_W-1:0] ph;
    logic lvl_bit;
    duty_slot = int'(idx) - int'(WORD_DUTY);
    div_slot  = int'(idx) - int'(WORD_DIV);
    res = '0;
    case (rt)
      REQ_TICK: begin
        for (int d = 0; d < NCH; d++) begin
          if (div_period[d] != '0) begin
            // A count at or above a lowered period also wraps here.
            if (int'(presc_cnt[d]) + 1 >= int'(div_period[d])) begin
              presc_cnt[d] = '0;
              phase_cnt[d] = phase_cnt[d] + 1'b1;
            end else begin
              presc_cnt[d] = presc_cnt[d] + 1'b1;
            end
          end
        end
      end
      REQ_WRITE: begin
        if (idx == WORD_MODE) begin
          chan_en    = data[NCH-1:0];
          chan_byp   = data[BYPASS_LSB +: NCH];
          mode_spare = data[SPARE_LSB +: SPARE_W];
        end else if (idx == WORD_POL) begin
          chan_inv = data[POL_LSB +: NCH];
        end else if (duty_slot >= 0 && duty_slot < NCH) begin
          duty_lvl[duty_slot] = data[LEVEL_W-1:0];
          duty_sel[duty_slot] = data[SEL_LSB +: SEL_W];
        end else if (div_slot >= 0 && div_slot < NCH) begin
          div_period[div_slot] = data[PERIOD_W-1:0];
        end
      end
      REQ_READ: begin
        if (idx == WORD_MODE) begin
          res.read_data[NCH-1:0]              = chan_en;
          res.read_data[BYPASS_LSB +: NCH]    = chan_byp;
          res.read_data[SPARE_LSB +: SPARE_W] = mode_spare;
        end else if (idx == WORD_POL) begin
          res.read_data[POL_LSB +: NCH] = chan_inv;
        end else if (duty_slot >= 0 && duty_slot < NCH) begin
          res.read_data[LEVEL_W-1:0]     = duty_lvl[duty_slot];
          res.read_data[SEL_LSB +: SEL_W] = duty_sel[duty_slot];
        end else if (div_slot >= 0 && div_slot < NCH) begin
          res.read_data[PERIOD_W-1:0] = div_period[div_slot];
        end
      end
      default: ;
    endcase
    for (int c = 0; c < NCH; c++) begin
      lvl_bit = 1'b0;
      if (chan_en[c]) begin
        if (chan_byp[c]) begin
          lvl_bit = 1'b1;
        end else begin
          // A selector past the last divider reads phase zero.
          ph = (int'(duty_sel[c]) < NCH) ? phase_cnt[duty_sel[c]] : '0;
          lvl_bit = (ph < duty_lvl[c]);
        end
      end
      res.pwm_level[c] = lvl_bit ^ chan_inv[c];
    end
    return res;
  endfunction

  function void note_mismatch(input string msg);
    if (mismatches < 10) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
    mismatches++;
  endfunction

  task automatic check_result();
    pwm_result_t exp_res;
    if (pending_results.size() == 0) begin
      note_mismatch($sformatf("result with nothing pending: read_data %h pwm_level %b",
                              out_ch.read_data, out_ch.pwm_level));
    end else begin
      exp_res = pending_results.pop_front();
      results_checked++;
      if (out_ch.read_data !== exp_res.read_data) begin
        note_mismatch($sformatf("read_data expected %h got %h",
                                exp_res.read_data, out_ch.read_data));
      end
      if (out_ch.pwm_level !== exp_res.pwm_level) begin
        note_mismatch($sformatf("pwm_level expected %b got %b",
                                exp_res.pwm_level, out_ch.pwm_level));
      end
    end
  endtask

  // Result side: check every transfer, then pick the next ready level.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_result();
      end
      out_ch.ready <= !hold_active && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Long output stall, counted here so the sender keeps running meanwhile.
  initial begin
    forever begin
      @(hold_start);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending.",
               cycle_count, pending_results.size());
      $display("multi_channel_pwm_shared_dividers: mismatch");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge of the transfer with valid still high.
  task automatic send_request(input req_t rt, input logic [IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= rt;
    in_ch.reg_index  <= idx;
    in_ch.write_data <= data;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pending_results.push_back(apply_request(rt, idx, data));
    requests_sent++;
    if (rt == REQ_READ) begin
      reads_sent++;
    end
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [IDX_W-1:0] mapped_index();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      return WORD_MODE;
    end else if (k <= NCH) begin
      return WORD_DUTY + IDX_W'(k - 1);
    end else if (k <= 2 * NCH) begin
      return WORD_DIV + IDX_W'(k - 1 - NCH);
    end
    return WORD_POL;
  endfunction

  // Mostly ticks and well-formed accesses with small periods and levels so the
  // phases cross the duty levels often; the rest is unmapped or idle noise.
  task automatic random_request(output req_t rt, output logic [IDX_W-1:0] idx,
                               output logic [WORD_W-1:0] data);
    int pick;
    int shape;
    pick  = $urandom_range(99);
    shape = $urandom_range(99);
    data  = $urandom();
    idx   = mapped_index();
    if (pick < 55) begin
      rt = REQ_TICK;
    end else if (pick < 80) begin
      rt = REQ_WRITE;
      if (idx == WORD_MODE && shape < 60) begin
        data[BYPASS_LSB +: NCH] = '0;
      end else if (idx >= WORD_DUTY && idx < WORD_DUTY + NCH && shape < 70) begin
        data[LEVEL_W-1:0] = LEVEL_W'($urandom_range(0, 40));
      end else if (idx >= WORD_DIV && idx < WORD_DIV + NCH) begin
        if (shape < 70) begin
          data[PERIOD_W-1:0] = PERIOD_W'($urandom_range(1, 5));
        end else if (shape < 80) begin
          data[PERIOD_W-1:0] = '0;
        end
      end
    end else if (pick < 94) begin
      rt = REQ_READ;
    end else begin
      rt  = req_t'($urandom_range(0, 3));
      idx = IDX_W'($urandom_range(0, 63));
    end
  endtask

  task automatic test_register_basics();
    send_request(REQ_READ, WORD_MODE, '0);
    send_request(REQ_WRITE, WORD_MODE, '1);
    send_request(REQ_READ, WORD_MODE, '0);
    send_request(REQ_WRITE, WORD_POL, '1);
    send_request(REQ_READ, WORD_POL, '1);
    send_request(REQ_WRITE, 6'd63, '1);
    send_request(REQ_READ, 6'd63, '0);
    send_request(REQ_NONE, WORD_MODE, '1);
    send_request(REQ_WRITE, WORD_DUTY, '1);
    send_request(REQ_READ, WORD_DUTY, '0);
    send_request(REQ_WRITE, WORD_DIV + 6'd3, '1);
    send_request(REQ_READ, WORD_DIV + 6'd3, '0);
    send_request(REQ_WRITE, WORD_MODE, 32'h0000_000F);
    send_request(REQ_WRITE, WORD_POL, '0);
    send_request(REQ_WRITE, WORD_DUTY + 6'd1, 32'h0000_0001);
    send_request(REQ_WRITE, WORD_DIV, 32'hFFFC_0005);
    repeat (3) send_request(REQ_TICK, WORD_MODE, '1);
    // Period drops below the running count, so the next tick wraps it.
    send_request(REQ_WRITE, WORD_DIV, 32'h0000_0002);
    send_request(REQ_TICK, WORD_MODE, '0);
    send_request(REQ_WRITE, WORD_DIV, '0);
    repeat (2) send_request(REQ_TICK, WORD_DIV, '0);
    send_request(REQ_READ, WORD_DIV, '0);
    pause_until_drained();
  endtask

  task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
    req_t rt;
    logic [IDX_W-1:0] idx;
    logic [WORD_W-1:0] data;
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    repeat (count) begin
      random_request(rt, idx, data);
      send_request(rt, idx, data);
    end
    pause_until_drained();
  endtask

  task automatic test_output_stall();
    req_t rt;
    logic [IDX_W-1:0] idx;
    logic [WORD_W-1:0] data;
    src_idle_pct = 0;
    -> hold_start;
    repeat (40) begin
      random_request(rt, idx, data);
      send_request(rt, idx, data);
    end
    pause_until_drained();
  endtask

  // Runs divider 0 at full rate with back-to-back ticks and a few reads mixed in.
  task automatic test_full_rate_ticks();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    send_request(REQ_WRITE, WORD_DIV, 32'h0000_0001);
    send_request(REQ_WRITE, WORD_DIV + 6'd1, 32'h0000_0003);
    send_request(REQ_WRITE, WORD_DUTY, 32'h0000_0800);
    send_request(REQ_WRITE, WORD_DUTY + 6'd1, 32'h0001_0100);
    send_request(REQ_WRITE, WORD_DUTY + 6'd2, 32'h0000_0FFF);
    send_request(REQ_WRITE, WORD_DUTY + 6'd3, 32'h0000_0001);
    send_request(REQ_WRITE, WORD_MODE, 32'h0000_000F);
    send_request(REQ_WRITE, WORD_POL, 32'h0000_0500);
    for (int i = 0; i < 130; i++) begin
      if (i % 29 == 10) begin
        send_request(REQ_READ, mapped_index(), $urandom());
      end else begin
        send_request(REQ_TICK, IDX_W'($urandom_range(0, 63)), $urandom());
      end
    end
    pause_until_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_TICK;
    in_ch.reg_index  = '0;
    in_ch.write_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_register_basics();
    test_random_traffic(150, 35, 68);
    test_output_stall();
    test_random_traffic(150, 68, 35);
    test_random_traffic(150, 0, 0);
    test_full_rate_ticks();

    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("Sent %0d requests (%0d reads) and checked %0d results with %0d mismatches,",
             requests_sent, reads_sent, results_checked, mismatches);
    $display("covering register access, prescaler corner cases, stalls and full-rate ticks.");
    if (mismatches == 0) begin
      $display("multi_channel_pwm_shared_dividers: match");
    end else begin
      $display("multi_channel_pwm_shared_dividers: mismatch");
    end
    $finish;
  end

endmodule
